// ----- hdl/zle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zle_pkg: shared types and constants for the zero-lag EMA filter
// Register indexes, register widths and reset values, the Q1.16 gain format
// and the tap flags that travel from the history ring to the smoothing stage.
// ----------------------------------------------------------------------------
package zle_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;

	// Register formats
	localparam int PERIOD_W = 7;
	localparam int ALPHA_W  = 17;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd9;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd13107;

	// Gain is unsigned Q1.16, 1.0 is the largest value used
	localparam int                 ALPHA_FRAC = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
	localparam int                 ALPHA_HALF = 1 << (ALPHA_FRAC - 1);

	// Flags attached to each request as it leaves the history ring
	typedef struct packed {
		logic warming;   // ring not yet full: pass the sample through
		logic seed;      // this request fills the ring: load the state
		logic lag_zero;  // tap is the current sample itself
	} zle_tap_t;

endpackage
`default_nettype wire

// ----- hdl/zle_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zle_ring: sample history ring
// Writes each accepted sample at the write pointer and reads the oldest
// entry (lag samples back) in the same cycle; the read data is registered.
// Tracks warm-up and flags the request that first fills the ring.
// ----------------------------------------------------------------------------
module zle_ring #(
	parameter int MAX_DEPTH   = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   restart,
	input  wire                                   ld,
	input  wire        [$clog2(MAX_DEPTH)-1:0]    lag,
	input  wire signed [SAMPLE_BITS-1:0]          sample,
	output logic signed [SAMPLE_BITS-1:0]         x_s1,
	output logic signed [SAMPLE_BITS-1:0]         rd_s1,
	output zle_pkg::zle_tap_t                     tap_s1
);
	import zle_pkg::*;

	localparam int AW = $clog2(MAX_DEPTH);

	logic [SAMPLE_BITS-1:0] mem [MAX_DEPTH];
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          wp_nxt;
	logic                   wrap;
	logic                   primed_q;

	// Advance the pointer, wrapping after the last ring slot
	assign wrap   = (wp_q == lag);
	assign wp_nxt = wrap ? '0 : wp_q + 1'b1;

	// Write the new sample, read the slot just past it (the oldest)
	always_ff @(posedge clk) begin
		if (ld) begin
			mem[wp_q] <= sample;
			rd_s1     <= $signed(mem[wp_nxt]);
		end
	end

	// Pointer and warm-up state; a period write restarts warm-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			primed_q <= 1'b0;
		end else if (restart) begin
			wp_q     <= '0;
			primed_q <= 1'b0;
		end else if (ld) begin
			wp_q <= wp_nxt;
			if (wrap) begin
				primed_q <= 1'b1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (ld) begin
			x_s1            <= sample;
			tap_s1.warming  <= !primed_q;
			tap_s1.seed     <= !primed_q && wrap;
			tap_s1.lag_zero <= (lag == '0);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/zle_smooth.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zle_smooth: lag correction, EMA update and output formatting
// Forms corrected = 2x - x[n-lag], updates the smoothed state with the Q1.16
// gain (rounded to nearest), then rounds and saturates the state into the
// output register. Warm-up requests pass the raw sample through.
// ----------------------------------------------------------------------------
module zle_smooth #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire                                clk,
	input  wire                                ld2,
	input  wire                                ld3,
	input  wire signed [SAMPLE_BITS-1:0]       x_s1,
	input  wire signed [SAMPLE_BITS-1:0]       rd_s1,
	input  wire zle_pkg::zle_tap_t             tap_s1,
	input  wire        [zle_pkg::ALPHA_W-1:0]  alpha,
	output logic signed [SAMPLE_BITS:0]        filtered,
	output logic                               warming
);
	import zle_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int SW  = SB + 2 + F;              // smoothed state width
	localparam int DW  = SW + 1;                  // difference width
	localparam int DHW = DW - ALPHA_FRAC;         // high part of difference
	localparam int IW  = DHW + ALPHA_W + 1;       // increment width
	localparam int LW  = ALPHA_W + ALPHA_FRAC;    // low partial product width

	localparam logic [SW:0] HALF_F = (SW + 1)'(1) << (F - 1);

	logic signed [SB-1:0]     past;
	logic signed [SB+1:0]     corr;
	logic signed [SW-1:0]     c_full;
	logic signed [DW-1:0]     diff;
	logic signed [DHW-1:0]    dh;
	logic [ALPHA_FRAC-1:0]    dl;
	logic signed [IW-1:0]     pp_hi;
	logic [LW-1:0]            pp_lo;
	logic [LW:0]              lo_rnd;
	logic [ALPHA_W:0]         lo_part;
	logic signed [IW-1:0]     incr;
	logic signed [SW-1:0]     s_new;
	logic signed [SW-1:0]     s_seed;
	logic signed [SW-1:0]     smoothed_q;
	logic signed [SB-1:0]     x_s2;
	logic                     warming_s2;
	logic [SW:0]              rnd;
	logic signed [SB+2:0]     rq;
	logic                     ovf;
	logic signed [SB:0]       sat;

	// Lag-corrected input; with no lag the tap is the sample itself
	assign past   = tap_s1.lag_zero ? x_s1 : rd_s1;
	assign corr   = {x_s1[SB-1], x_s1, 1'b0} - {{2{past[SB-1]}}, past};
	assign c_full = {corr, {F{1'b0}}};
	assign diff   = {c_full[SW-1], c_full} - {smoothed_q[SW-1], smoothed_q};

	// Split the difference so each product stays narrow
	assign dh    = diff[DW-1:ALPHA_FRAC];
	assign dl    = diff[ALPHA_FRAC-1:0];
	assign pp_hi = $signed({1'b0, alpha}) * dh;
	assign pp_lo = alpha * dl;

	// Round the low product to nearest, ties up, and merge
	assign lo_rnd  = {1'b0, pp_lo} + (LW + 1)'(ALPHA_HALF);
	assign lo_part = lo_rnd[LW:ALPHA_FRAC];
	assign incr    = pp_hi + $signed({{(IW - ALPHA_W - 1){1'b0}}, lo_part});
	assign s_new   = smoothed_q + $signed(incr[SW-1:0]);
	assign s_seed  = {{2{past[SB-1]}}, past, {F{1'b0}}};

	// Stage 2: update the state, seed it when the ring first fills
	always_ff @(posedge clk) begin
		if (ld2) begin
			x_s2       <= x_s1;
			warming_s2 <= tap_s1.warming;
			if (tap_s1.seed) begin
				smoothed_q <= s_seed;
			end else if (!tap_s1.warming) begin
				smoothed_q <= s_new;
			end
		end
	end

	// Round the state to an integer and clamp to the output range
	assign rnd = {smoothed_q[SW-1], smoothed_q} + HALF_F;
	assign rq  = rnd[SW:F];
	assign ovf = !((rq[SB+2:SB] == '0) || (rq[SB+2:SB] == '1));
	assign sat = ovf ? (rq[SB+2] ? {1'b1, {SB{1'b0}}} : {1'b0, {SB{1'b1}}})
	                 : rq[SB:0];

	// Output register
	always_ff @(posedge clk) begin
		if (ld3) begin
			filtered <= warming_s2 ? {x_s2[SB-1], x_s2} : sat;
			warming  <= warming_s2;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/zero_lag_ema_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zero_lag_ema_filter: zero-lag exponential moving average
// Ring memory of recent samples feeds a lag-corrected EMA with a software
// supplied Q1.16 gain; warm-up passes samples through until the ring fills.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_stall    sample
//   out      from block out_valid/out_stall  filtered, warming
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// One sample per cycle while the output is not stalled; each result passes
// the ring read on the accepting edge, then the state update and the output
// register. The state update loop (subtract, Q1.16 multiply, add) sets the
// cycle time.
// Reset restores period 9 and alpha 13107; history needs no clearing pass,
// since warm-up writes every slot before it is used.
// A stalled output holds its result; earlier stages keep filling until the
// pipeline is full, and only then is the input stalled.
// ----------------------------------------------------------------------------
module zero_lag_ema_filter #(
	parameter int MAX_DEPTH     = 64,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire        [zle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire        [zle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [SAMPLE_BITS-1:0]         sample,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [SAMPLE_BITS:0]          filtered,
	output logic                                 warming
);
	import zle_pkg::*;

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int RW = PERIOD_W - 1;
	localparam int LW = (AW > RW) ? AW : RW;

	logic [PERIOD_W-1:0]    period_q;
	logic [ALPHA_W-1:0]     alpha_q;
	logic                   restart;
	logic [PERIOD_W-1:0]    p_eff;
	logic [PERIOD_W-1:0]    p_less;
	logic [LW-1:0]          lag_w;
	logic [LW-1:0]          lag_lim;
	logic [AW-1:0]          lag;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   out_free;
	logic                   s2_free;
	logic                   s1_free;
	logic                   accept;
	logic                   mv1;
	logic                   mv2;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	zle_tap_t               tap_s1;

	// Configuration registers; clamp the gain to 1.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			alpha_q  <= ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_ALPHA:  alpha_q  <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == REG_PERIOD);

	// Delay tap (period-1)/2, zero period as one, limited to the ring size
	assign p_eff   = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign p_less  = p_eff - PERIOD_W'(1);
	assign lag_w   = LW'(p_less[PERIOD_W-1:1]);
	assign lag_lim = LW'(MAX_DEPTH - 1);
	assign lag     = AW'((lag_w > lag_lim) ? lag_lim : lag_w);

	// Pipeline flow: a stage takes a request when it is empty or draining
	assign out_free = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;
	assign mv1      = valid_s1 && s2_free;
	assign mv2      = valid_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid <= valid_s2;
			end
		end
	end

	zle_ring #(
		.MAX_DEPTH   (MAX_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.ld      (accept),
		.lag     (lag),
		.sample  (sample),
		.x_s1    (x_s1),
		.rd_s1   (rd_s1),
		.tap_s1  (tap_s1)
	);

	zle_smooth #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_smooth (
		.clk      (clk),
		.ld2      (mv1),
		.ld3      (mv2),
		.x_s1     (x_s1),
		.rd_s1    (rd_s1),
		.tap_s1   (tap_s1),
		.alpha    (alpha_q),
		.filtered (filtered),
		.warming  (warming)
	);

`ifndef ASSERT_OFF
	// Input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// The request that seeds the state is still a warm-up request
	a_seed_warm: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && tap_s1.seed) |-> tap_s1.warming)
		else $error("seed flagged on a primed request");

	// A blocked stage 1 request stays in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> valid_s1)
		else $error("stage 1 request dropped while blocked");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_zero_lag_ema_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zero_lag_ema_filter: self-checking bench for the zero-lag EMA filter
// A directed table covers warm-up pass-through, the seeding step, output
// saturation, zero lag, zero and saturated gain, masked period writes and
// ignored register indexes. Randomized phases follow, each with new register
// settings and a stream of samples. Every accepted request runs through a
// bit-accurate fixed-point EMA predictor, and each accepted result is checked
// field by field against the oldest prediction. The sender idles in bursts
// and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_zero_lag_ema_filter;
	import zle_pkg::*;

	localparam int SMP_W       = 16;
	localparam int OUT_W       = SMP_W + 1;
	localparam int FRAC_W      = 16;
	localparam int ACC_W       = SMP_W + 2 + FRAC_W;
	localparam int RING_MAX    = 64;
	localparam int HOLD_CYCLES = 8;
	localparam int ITEM_GOAL   = 1850;
	localparam int CYCLE_LIMIT = 400000;

	localparam longint OUT_HI = (longint'(1) <<< SMP_W) - 1;
	localparam longint OUT_LO = -(longint'(1) <<< SMP_W);

	// Indexes outside the register map, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum int {ROW_CFG, ROW_SAMPLE} row_kind_t;
	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_BEAT, STALL_HEAVY} stall_mode_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		bit                     typed;
		logic signed [OUT_W-1:0] filtered;
		logic                   warming;
	} stim_row_t;

	typedef struct {
		logic signed [OUT_W-1:0] filtered;
		logic                    warming;
	} filt_result_t;

	// Block ports
	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic signed [SMP_W-1:0]     sample    = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [OUT_W-1:0]     filtered;
	logic                        warming;

	// Typed expectation travelling with the current request
	logic                        chk_typed    = 1'b0;
	logic signed [OUT_W-1:0]     chk_filtered = '0;
	logic                        chk_warming  = 1'b0;

	// Predictor state
	logic [PERIOD_W-1:0]         mdl_period;
	logic [ALPHA_W-1:0]          mdl_alpha;
	logic signed [SMP_W-1:0]     ring_mem [RING_MAX];
	int                          ring_wr;
	int                          ring_fill;
	bit                          primed;
	logic signed [ACC_W-1:0]     acc;

	filt_result_t                awaited_outputs [$];
	stim_row_t                   plan [$];
	int                          mismatch_count = 0;
	int unsigned                 cycle_count = 0;
	int                          burst_left = 0;

	zero_lag_ema_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered),
		.warming   (warming)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort on a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Ring depth for a period value: lag + 1, period zero acts as one
	function automatic int ring_depth(input logic [PERIOD_W-1:0] per);
		int pe;
		int lag;
		pe  = (per == 0) ? 1 : int'(per);
		lag = (pe - 1) / 2;
		if (lag > RING_MAX - 1) begin
			lag = RING_MAX - 1;
		end
		return lag + 1;
	endfunction

	function automatic void restart_warmup();
		ring_wr   = 0;
		ring_fill = 0;
		primed    = 1'b0;
		acc       = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PERIOD: begin
				mdl_period = data[PERIOD_W-1:0];
				restart_warmup();
			end
			REG_ALPHA: begin
				mdl_alpha = data[ALPHA_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the EMA by one sample and produce its result
	task automatic ema_step(input logic signed [SMP_W-1:0] x, output filt_result_t r);
		int     depth;
		longint past;
		longint corr;
		longint a;
		longint d;
		longint dh;
		longint dl;
		longint acc_l;
		longint rnd;
		depth = ring_depth(mdl_period);
		if (ring_wr >= depth) begin
			ring_wr = 0;
		end
		ring_mem[ring_wr] = x;
		ring_wr = (ring_wr + 1 >= depth) ? 0 : ring_wr + 1;
		if (ring_fill < depth) begin
			ring_fill++;
		end
		past = longint'(ring_mem[ring_wr]);
		if (!primed) begin
			// pass through; the filling sample seeds the state with the oldest tap
			if (ring_fill >= depth) begin
				primed = 1'b1;
				acc    = ACC_W'(past <<< FRAC_W);
			end
			r.filtered = OUT_W'(x);
			r.warming  = 1'b1;
		end else begin
			corr  = 2 * longint'(x) - past;
			a     = (mdl_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(mdl_alpha);
			d     = (corr <<< FRAC_W) - longint'(acc);
			dh    = d >>> ALPHA_FRAC;
			dl    = d - dh * (longint'(1) <<< ALPHA_FRAC);
			acc_l = longint'(acc) + a * dh + ((a * dl + ALPHA_HALF) >>> ALPHA_FRAC);
			acc   = acc_l[ACC_W-1:0];
			rnd   = (acc_l + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			if (rnd > OUT_HI) begin
				rnd = OUT_HI;
			end
			if (rnd < OUT_LO) begin
				rnd = OUT_LO;
			end
			r.filtered = rnd[OUT_W-1:0];
			r.warming  = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Track configuration, predict accepted requests, check accepted results
	always @(posedge clk) begin : scoreboard
		filt_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				apply_reg(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				ema_step(sample, want);
				if (chk_typed) begin
					want.filtered = chk_filtered;
					want.warming  = chk_warming;
				end
				awaited_outputs.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (awaited_outputs.size() == 0) begin
					flag_mismatch($sformatf("result %0d/%0d with none pending",
						filtered, warming));
				end else begin
					want = awaited_outputs.pop_front();
					if (filtered !== want.filtered) begin
						flag_mismatch($sformatf("filtered %0d, wanted %0d",
							filtered, want.filtered));
					end
					if (warming !== want.warming) begin
						flag_mismatch($sformatf("warming %0d, wanted %0d",
							warming, want.warming));
					end
				end
			end
		end
	end

	// Stall the output on a pattern that is chosen anew at random
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          beat_len   = 3;
	int          beat_pos   = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 300);
			beat_len   = $urandom_range(2, 6);
		end else begin
			stall_left--;
		end
		beat_pos = (beat_pos + 1) % beat_len;
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_BEAT:   out_stall <= (beat_pos == 0);
			default:      out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
		stim_row_t row;
		row.kind     = ROW_CFG;
		row.idx      = idx;
		row.data     = data[CFG_DATA_W-1:0];
		row.typed    = 1'b0;
		row.filtered = '0;
		row.warming  = 1'b0;
		plan.push_back(row);
	endfunction

	function automatic void add_smp(input int s, input bit typed, input int ef, input bit ew);
		stim_row_t row;
		row.kind     = ROW_SAMPLE;
		row.idx      = '0;
		row.data     = s[CFG_DATA_W-1:0];
		row.typed    = typed;
		row.filtered = ef[OUT_W-1:0];
		row.warming  = ew;
		plan.push_back(row);
	endfunction

	function automatic logic signed [SMP_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		end else if (r <= 2) begin
			return SMP_W'($urandom_range(0, 200) - 100);
		end
		return SMP_W'($urandom);
	endfunction

	// Present one request, idling between bursts, and hold it until accepted
	task automatic push_sample(input logic signed [SMP_W-1:0] s, input bit typed,
			input logic signed [OUT_W-1:0] ef, input logic ew);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		sample       <= s;
		chk_typed    <= typed;
		chk_filtered <= ef;
		chk_warming  <= ew;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every pending result has drained
	task automatic settle_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		bit                    busy;
		int                    items_sent;
		int                    n;
		int                    r;
		int                    pe;
		logic [PERIOD_W-1:0]   cur_period;
		logic [CFG_DATA_W-1:0] val;

		mdl_period = PERIOD_RESET;
		mdl_alpha  = ALPHA_RESET;
		foreach (ring_mem[i]) begin
			ring_mem[i] = '0;
		end
		restart_warmup();

		// Reset values: period 9 passes five samples through
		add_smp(0, 1, 0, 1);
		add_smp(32767, 1, 32767, 1);
		add_smp(-32768, 1, -32768, 1);
		add_smp(-1, 1, -1, 1);
		add_smp(1, 1, 1, 1);
		add_smp(12345, 0, 0, 0);
		add_smp(-20000, 0, 0, 0);
		// Unity gain, lag one: output equals the corrected value, then saturates
		add_cfg(REG_ALPHA, 65536);
		add_cfg(REG_PERIOD, 3);
		add_smp(-32768, 1, -32768, 1);
		add_smp(32767, 1, 32767, 1);
		add_smp(32767, 1, 32767, 0);
		add_smp(-32768, 1, -65536, 0);
		add_smp(32767, 1, 65535, 0);
		// Gain above one saturates; lag zero taps the current sample
		add_cfg(REG_ALPHA, 131071);
		add_cfg(REG_PERIOD, 1);
		add_smp(-32768, 1, -32768, 1);
		add_smp(32767, 1, 32767, 0);
		add_smp(100, 1, 100, 0);
		// Zero gain holds the seeded state; period zero acts as one
		add_cfg(REG_ALPHA, 0);
		add_cfg(REG_PERIOD, 0);
		add_smp(5, 1, 5, 1);
		add_smp(-32768, 1, 5, 0);
		add_smp(32767, 1, 5, 0);
		// Spare indexes do nothing; period write keeps only its low bits
		add_cfg(REG_SPARE_A, 131071);
		add_cfg(REG_SPARE_B, 65536);
		add_cfg(REG_PERIOD, 'h1FF85);
		add_smp(-7, 1, -7, 1);
		add_smp(8, 1, 8, 1);
		add_smp(9, 1, 9, 1);
		add_smp(1000, 1, -7, 0);
		// Gain change without restart
		add_cfg(REG_ALPHA, 21845);
		add_smp(-32768, 0, 0, 0);
		add_smp(32767, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		busy       = 1'b0;
		items_sent = 0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (busy) begin
					settle_pipe();
					busy = 1'b0;
				end
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				push_sample(plan[i].data[SMP_W-1:0], plan[i].typed, plan[i].filtered,
					plan[i].warming);
				busy = 1'b1;
				items_sent++;
			end
		end
		cur_period = 7'd5;

		// Random phases, each with fresh settings written while idle
		while (items_sent < ITEM_GOAL) begin
			settle_pipe();
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 19);
				case (r)
					0:       val = '0;
					1:       val = CFG_DATA_W'(1);
					2:       val = CFG_DATA_W'(127);
					3:       val = CFG_DATA_W'($urandom_range(0, 131071));
					4:       val = CFG_DATA_W'(2);
					default: val = CFG_DATA_W'($urandom_range(1, 15));
				endcase
				write_reg(REG_PERIOD, val);
				cur_period = val[PERIOD_W-1:0];
			end
			if ($urandom_range(0, 4) == 0) begin
				write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom_range(0, 131071)));
			end
			pe = (cur_period == 0) ? 1 : int'(cur_period);
			r  = $urandom_range(0, 9);
			case (r)
				0:       val = '0;
				1:       val = ALPHA_ONE;
				2:       val = CFG_DATA_W'($urandom_range(65537, 131071));
				3:       val = CFG_DATA_W'(1);
				4:       val = CFG_DATA_W'($urandom_range(0, 131071));
				default: val = CFG_DATA_W'((2 * 65536) / (pe + 1));
			endcase
			write_reg(REG_ALPHA, val);
			n = ring_depth(cur_period) + $urandom_range(20, 90);
			repeat (n) begin
				push_sample(rand_sample(), 1'b0, '0, 1'b0);
				items_sent++;
			end
		end

		settle_pipe();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/zle_pkg.sv
hdl/zle_ring.sv
hdl/zle_smooth.sv
hdl/zero_lag_ema_filter.sv
sim/tb_zero_lag_ema_filter.sv
